### sv/mwn_pkg.sv
// Shared types and constants of the Moore window neighbour engine.
`default_nettype none

package mwn_pkg;

    // configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int PLANE_ROWS_W = 16;
    localparam int PLANE_COLS_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOORE_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_TOP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_MID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_BOT = 3'd5;

    // smallest plane edge; smaller settings act as this
    localparam int MIN_DIM = 3;

    // result fields
    localparam int ROW_W     = 16;
    localparam int COL_OUT_W = 10;
    localparam int LIVE_W    = 4;
    localparam int PSUM_W    = 18;
    localparam int WSUM_W    = 27;

    // Q8.8 weights
    localparam int WEIGHT_W  = 16;
    localparam int FRAC_BITS = 8;

    // result queue
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = 3;
    localparam int RES_CNT_W = 4;

    typedef struct packed {
        logic                 valid;
        logic                 emit;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
    } mwn_tag_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [LIVE_W-1:0]    live;
        logic [PSUM_W-1:0]    psum;
        logic [WSUM_W-1:0]    wsum;
    } mwn_result_t;

endpackage

`default_nettype wire

### sv/mwn_line_buffer.sv
// Two line stores with read-modify-write and same-column forwarding.
`default_nettype none

module mwn_line_buffer
    import mwn_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int STATE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mwn_tag_t                         rd_tag,
    input  logic [$clog2(MAX_COLS)-1:0]      rd_addr,
    input  logic signed [STATE_BITS-1:0]     rd_cell,
    output mwn_tag_t                         col_tag,
    output logic signed [STATE_BITS-1:0]     col_above,
    output logic signed [STATE_BITS-1:0]     col_mid,
    output logic signed [STATE_BITS-1:0]     col_cell
);

    localparam int ADDR_W = $clog2(MAX_COLS);

    logic [STATE_BITS-1:0] upper_mem [MAX_COLS];
    logic [STATE_BITS-1:0] lower_mem [MAX_COLS];

    logic [STATE_BITS-1:0] up_rd_reg;
    logic [STATE_BITS-1:0] lo_rd_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [STATE_BITS-1:0] cell_reg;
    logic [STATE_BITS-1:0] fwd_up_reg;
    logic [STATE_BITS-1:0] fwd_lo_reg;
    logic                  fwd_reg;
    mwn_tag_t              tag_reg;

    logic [STATE_BITS-1:0] above_val;
    logic [STATE_BITS-1:0] mid_val;
    logic                  hit;

    assign above_val = fwd_reg ? fwd_up_reg : up_rd_reg;
    assign mid_val   = fwd_reg ? fwd_lo_reg : lo_rd_reg;
    // the column being written back this cycle is read again by the new transfer
    assign hit       = rd_tag.valid && tag_reg.valid && (rd_addr == addr_reg);

    always_ff @(posedge aclk) begin
        if (rd_tag.valid) begin
            up_rd_reg <= upper_mem[rd_addr];
            lo_rd_reg <= lower_mem[rd_addr];
        end
        if (tag_reg.valid) begin
            upper_mem[addr_reg] <= mid_val;
            lower_mem[addr_reg] <= cell_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
            fwd_reg <= 1'b0;
        end else begin
            tag_reg <= rd_tag;
            fwd_reg <= hit;
        end
        addr_reg   <= rd_addr;
        cell_reg   <= rd_cell;
        fwd_up_reg <= mid_val;
        fwd_lo_reg <= cell_reg;
    end

    assign col_tag   = tag_reg;
    assign col_above = above_val;
    assign col_mid   = mid_val;
    assign col_cell  = cell_reg;

endmodule

`default_nettype wire

### sv/mwn_window_alu.sv
// 3x3 window register and the pipelined neighbour count, sum and weighted sum.
`default_nettype none

module mwn_window_alu
    import mwn_pkg::*;
#(
    parameter int STATE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mwn_tag_t                     col_tag,
    input  logic signed [STATE_BITS-1:0] col_above,
    input  logic signed [STATE_BITS-1:0] col_mid,
    input  logic signed [STATE_BITS-1:0] col_cell,
    input  logic [CFG_DATA_W-1:0]        weights_top,
    input  logic [CFG_DATA_W-1:0]        weights_middle,
    input  logic [CFG_DATA_W-1:0]        weights_bottom,
    input  logic                         moore_mode,
    output mwn_tag_t                     res_tag,
    output mwn_result_t                  res_data
);

    localparam int PROD_W     = STATE_BITS + WEIGHT_W;
    localparam int RSUM_W     = PROD_W + 2;
    localparam int ACC_W      = PROD_W + 4;
    localparam int PS_W       = STATE_BITS + 2;
    localparam int CENTRE_IDX = 4;
    localparam logic signed [ACC_W-1:0] ROUND_ADJ = ACC_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [ACC_W-1:0] ACC_ZERO  = '0;

    logic [2:0][CFG_DATA_W-1:0]    wrow;
    logic signed [WEIGHT_W-1:0]    wgt [9];

    logic signed [STATE_BITS-1:0]  win_reg [9];
    logic signed [PROD_W-1:0]      prod_reg [9];
    logic signed [RSUM_W-1:0]      rsum_reg [3];
    logic [LIVE_W-1:0]             live_a, live_b_reg, live_c_reg;
    logic [PS_W-1:0]               psum_a, psum_b_reg, psum_c_reg;
    mwn_tag_t                      tag_a_reg, tag_b_reg, tag_c_reg;

    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       acc_adj;
    logic signed [ACC_W-1:0]       quot;

    assign wrow = {weights_bottom, weights_middle, weights_top};

    for (genvar wr = 0; wr < 3; wr++) begin : g_wrow
        for (genvar wc = 0; wc < 3; wc++) begin : g_wcol
            assign wgt[wr*3 + wc] = wrow[wr][wc*WEIGHT_W +: WEIGHT_W];
        end
    end

    // advance the window by one column per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (col_tag.valid) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k*3]     <= win_reg[k*3 + 1];
                win_reg[k*3 + 1] <= win_reg[k*3 + 2];
            end
            win_reg[2] <= col_above;
            win_reg[5] <= col_mid;
            win_reg[8] <= col_cell;
        end
    end

    always_comb begin
        live_a = '0;
        psum_a = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != CENTRE_IDX && !win_reg[k][STATE_BITS-1] && (win_reg[k] != '0)) begin
                live_a = live_a + LIVE_W'(1);
                psum_a = psum_a + PS_W'(unsigned'(win_reg[k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 9; k++) begin
            prod_reg[k] <= win_reg[k] * wgt[k];
        end
        live_b_reg <= live_a;
        psum_b_reg <= psum_a;
        for (int k = 0; k < 3; k++) begin
            rsum_reg[k] <= RSUM_W'(prod_reg[k*3]) + RSUM_W'(prod_reg[k*3 + 1])
                         + RSUM_W'(prod_reg[k*3 + 2]);
        end
        live_c_reg <= live_b_reg;
        psum_c_reg <= psum_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end else begin
            tag_a_reg <= col_tag;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    // divide by 256 rounding toward zero: bias negative sums before the shift
    always_comb begin
        acc     = ACC_W'(rsum_reg[0]) + ACC_W'(rsum_reg[1]) + ACC_W'(rsum_reg[2]);
        acc_adj = acc + (acc[ACC_W-1] ? ROUND_ADJ : ACC_ZERO);
        quot    = acc_adj >>> FRAC_BITS;
    end

    always_comb begin
        res_tag       = tag_c_reg;
        res_data.row  = tag_c_reg.row;
        res_data.col  = tag_c_reg.col;
        res_data.live = moore_mode ? live_c_reg : '0;
        res_data.psum = moore_mode ? PSUM_W'(psum_c_reg) : '0;
        res_data.wsum = moore_mode ? WSUM_W'(quot) : '0;
    end

endmodule

`default_nettype wire

### sv/mwn_result_fifo.sv
// Small result queue that parts the compute pipeline from the output channel.
`default_nettype none

module mwn_result_fifo
    import mwn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  mwn_result_t          push_data,
    input  logic                 pop,
    output logic                 out_valid,
    output mwn_result_t          out_data,
    output logic [RES_CNT_W-1:0] level
);

    mwn_result_t            store [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg;
    logic [RES_PTR_W-1:0]   rd_ptr_reg;
    logic [RES_CNT_W-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            end
            count_reg <= count_reg + RES_CNT_W'(push) - RES_CNT_W'(pop);
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = store[rd_ptr_reg];
    assign level     = count_reg;

endmodule

`default_nettype wire

### sv/moore_window_neighbor_engine.sv
// Moore window neighbour engine: 3x3 neighbour statistics over a raster cell stream.
//
// Cells enter on the s_ channel in raster order, one transfer per clock when
// s_valid and s_ready are high; s_frame_start puts a cell at position (0,0).
// For every interior cell one result leaves on the m_ channel: centre row and
// column, live neighbour count, sum of positive neighbours and the Q8.8
// weighted 3x3 sum divided by 256 toward zero (zero with Moore mode off). Border cells give no result.
// Registers are written on the cfg_ channel (always ready); the user writes them
// only while no cell is in flight, which the block does not enforce. Geometry
// takes effect at the next cell. Throughput is one cell per clock while s_ready
// is high. The cell that completes a window passes line-store read, window
// shift, multiply, row sums, then a final add into the result queue.
// The line stores are single-write, single-read memories; a column read in
// the cycle its previous value is written back is forwarded.
// When m_ready is low the 8-entry result queue absorbs results; s_ready drops
// once cells in flight plus queued results reach 8, and nothing is lost.
// Reset clears position, window, pipeline and queue; registers return to
// 3 rows, 3 columns, Moore mode and zero weights. Line stores are not cleared.
`default_nettype none

module moore_window_neighbor_engine
    import mwn_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int STATE_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [15:0]       s_cell_value,
    input  logic                     s_frame_start,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ROW_W-1:0]         m_center_row,
    output logic [COL_OUT_W-1:0]     m_center_col,
    output logic [LIVE_W-1:0]        m_live_count,
    output logic [PSUM_W-1:0]        m_positive_sum,
    output logic signed [WSUM_W-1:0] m_weighted_total,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int GEO_W  = (CNT_W > PLANE_COLS_W) ? CNT_W : PLANE_COLS_W;

    // configuration
    logic [PLANE_ROWS_W-1:0] rows_reg;
    logic [PLANE_COLS_W-1:0] cols_reg;
    logic                    mode_reg;
    logic [CFG_DATA_W-1:0]   w_top_reg, w_mid_reg, w_bot_reg;

    // raster position
    logic [ROW_W-1:0]        row_pos_reg, row_pos_next;
    logic [ADDR_W-1:0]       col_pos_reg, col_pos_next;

    logic [ROW_W-1:0]        rows_eff;
    logic [GEO_W-1:0]        cols_wide, cols_eff;
    logic [ROW_W:0]          r_a, r_b, r_inc;
    logic [ADDR_W-1:0]       c_a, c_cur;
    logic [ROW_W-1:0]        r_cur;
    logic [CNT_W-1:0]        c_inc;

    logic                         accept;
    mwn_tag_t                     acc_tag;
    logic signed [STATE_BITS-1:0] cell_in;

    mwn_tag_t                     col_tag;
    logic signed [STATE_BITS-1:0] col_above, col_mid, col_cell;
    mwn_tag_t                     res_tag;
    mwn_result_t                  res_data;
    mwn_result_t                  out_data;

    logic                    res_push, res_drop, res_pop;
    logic [RES_CNT_W-1:0]    occ_reg, occ_next;
    logic [RES_CNT_W-1:0]    fifo_level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= PLANE_ROWS_W'(MIN_DIM);
            cols_reg  <= PLANE_COLS_W'(MIN_DIM);
            mode_reg  <= 1'b1;
            w_top_reg <= '0;
            w_mid_reg <= '0;
            w_bot_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PLANE_ROWS:  rows_reg  <= cfg_data[PLANE_ROWS_W-1:0];
                REG_PLANE_COLS:  cols_reg  <= cfg_data[PLANE_COLS_W-1:0];
                REG_MOORE_MODE:  mode_reg  <= cfg_data[0];
                REG_WEIGHTS_TOP: w_top_reg <= cfg_data;
                REG_WEIGHTS_MID: w_mid_reg <= cfg_data;
                REG_WEIGHTS_BOT: w_bot_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp geometry
    always_comb begin
        rows_eff  = (rows_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : rows_reg;
        cols_wide = GEO_W'(cols_reg);
        priority if (cols_wide < GEO_W'(MIN_DIM)) begin
            cols_eff = GEO_W'(MIN_DIM);
        end else if (cols_wide > GEO_W'(MAX_COLS)) begin
            cols_eff = GEO_W'(MAX_COLS);
        end else begin
            cols_eff = cols_wide;
        end
    end

    // position of this cell, then of the next one
    always_comb begin
        r_a = s_frame_start ? '0 : {1'b0, row_pos_reg};
        c_a = s_frame_start ? '0 : col_pos_reg;
        if (GEO_W'(c_a) >= cols_eff) begin
            c_cur = '0;
            r_b   = r_a + (ROW_W+1)'(1);
        end else begin
            c_cur = c_a;
            r_b   = r_a;
        end
        r_cur = (r_b >= {1'b0, rows_eff}) ? '0 : r_b[ROW_W-1:0];

        c_inc = CNT_W'(c_cur) + CNT_W'(1);
        r_inc = {1'b0, r_cur} + (ROW_W+1)'(1);
        if (GEO_W'(c_inc) >= cols_eff) begin
            col_pos_next = '0;
            row_pos_next = (r_inc >= {1'b0, rows_eff}) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_pos_next = c_inc[ADDR_W-1:0];
            row_pos_next = r_cur;
        end
    end

    assign s_ready = (occ_reg < RES_CNT_W'(RES_DEPTH));
    assign accept  = s_valid && s_ready;
    assign cell_in = STATE_BITS'(s_cell_value);

    always_comb begin
        acc_tag.valid = accept;
        acc_tag.emit  = (r_cur >= ROW_W'(2)) && (c_cur >= ADDR_W'(2));
        acc_tag.row   = r_cur - ROW_W'(1);
        acc_tag.col   = COL_OUT_W'(c_cur - ADDR_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end else if (accept) begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    mwn_line_buffer #(
        .MAX_COLS   (MAX_COLS),
        .STATE_BITS (STATE_BITS)
    ) u_line_buffer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_tag    (acc_tag),
        .rd_addr   (c_cur),
        .rd_cell   (cell_in),
        .col_tag   (col_tag),
        .col_above (col_above),
        .col_mid   (col_mid),
        .col_cell  (col_cell)
    );

    mwn_window_alu #(
        .STATE_BITS (STATE_BITS)
    ) u_window_alu (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .col_tag        (col_tag),
        .col_above      (col_above),
        .col_mid        (col_mid),
        .col_cell       (col_cell),
        .weights_top    (w_top_reg),
        .weights_middle (w_mid_reg),
        .weights_bottom (w_bot_reg),
        .moore_mode     (mode_reg),
        .res_tag        (res_tag),
        .res_data       (res_data)
    );

    assign res_push = res_tag.valid && res_tag.emit;
    assign res_drop = res_tag.valid && !res_tag.emit;
    assign res_pop  = m_valid && m_ready;

    mwn_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .pop       (res_pop),
        .out_valid (m_valid),
        .out_data  (out_data),
        .level     (fifo_level)
    );

    // count cells in flight plus queued results; hold input once the queue could fill
    assign occ_next = occ_reg + RES_CNT_W'(accept) - RES_CNT_W'(res_drop)
                    - RES_CNT_W'(res_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign m_center_row     = out_data.row;
    assign m_center_col     = out_data.col;
    assign m_live_count     = out_data.live;
    assign m_positive_sum   = out_data.psum;
    assign m_weighted_total = out_data.wsum;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (fifo_level < RES_CNT_W'(RES_DEPTH)))
        else $error("result pushed into a full queue");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg <= RES_CNT_W'(RES_DEPTH)) && (fifo_level <= occ_reg))
        else $error("occupancy count out of step with the result queue");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && (occ_reg == '0)))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Moore window neighbour engine: raster planes in, 3x3 results checked.
module testbench;
    import mwn_pkg::*;

    localparam int LINE_DEPTH     = 1024;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 12;    // leave margin for results still in the pipeline
    localparam int WATCHDOG_LIMIT = 2000;  // many times the longest quiet stretch of a good run
    localparam int PRINT_LIMIT    = 40;
    localparam int PHASE_ITEMS    = 40;

    // indexes that select no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [WEIGHT_W-1:0] W_MOST_NEG  = 16'h8000;
    localparam logic [WEIGHT_W-1:0] W_MOST_POS  = 16'h7FFF;
    localparam logic [WEIGHT_W-1:0] W_ONE       = 16'h0100;
    localparam logic [WEIGHT_W-1:0] W_MINUS_LSB = 16'hFFFF;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic signed [15:0]       s_cell_value  = '0;
    logic                     s_frame_start = 1'b0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [ROW_W-1:0]         m_center_row;
    logic [COL_OUT_W-1:0]     m_center_col;
    logic [LIVE_W-1:0]        m_live_count;
    logic [PSUM_W-1:0]        m_positive_sum;
    logic signed [WSUM_W-1:0] m_weighted_total;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [CFG_DATA_W-1:0]    cfg_data      = '0;

    // register copies, as the block holds them
    logic [PLANE_ROWS_W-1:0] set_rows    = 16'd3;
    logic [PLANE_COLS_W-1:0] set_cols    = 11'd3;
    logic                    set_moore   = 1'b1;
    logic [CFG_DATA_W-1:0]   set_weights [3] = '{48'd0, 48'd0, 48'd0};

    // raster state of the predictor
    logic signed [15:0] line_older [LINE_DEPTH] = '{default: '0};
    logic signed [15:0] line_newer [LINE_DEPTH] = '{default: '0};
    logic signed [15:0] nbhd [9] = '{default: '0};
    int raster_row = 0;
    int raster_col = 0;

    mwn_result_t pending_results [$];
    int err_count      = 0;
    int quiet_cycles   = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    moore_window_neighbor_engine uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cell_value    (s_cell_value),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_center_row    (m_center_row),
        .m_center_col    (m_center_col),
        .m_live_count    (m_live_count),
        .m_positive_sum  (m_positive_sum),
        .m_weighted_total(m_weighted_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic int eff_rows();
        if (set_rows < MIN_DIM) return MIN_DIM;
        return int'(set_rows);
    endfunction

    function automatic int eff_cols();
        if (set_cols < MIN_DIM) return MIN_DIM;
        if (set_cols > LINE_DEPTH) return LINE_DEPTH;
        return int'(set_cols);
    endfunction

    // Advance the raster by one cell and queue the result it completes, if any.
    function automatic void slide_window(input logic signed [15:0] state_in, input logic start);
        int rows, cols, r, c, live;
        logic signed [15:0] above, mid;
        logic signed [63:0] acc, term_s, term_w;
        logic [31:0] psum;
        mwn_result_t res;
        rows = eff_rows();
        cols = eff_cols();
        if (start) begin
            raster_row = 0;
            raster_col = 0;
        end
        // geometry may have shrunk under the current position
        if (raster_col >= cols) begin
            raster_col = 0;
            raster_row++;
        end
        if (raster_row >= rows) raster_row = 0;
        r = raster_row;
        c = raster_col;
        above = line_older[c];
        mid   = line_newer[c];
        line_older[c] = mid;
        line_newer[c] = state_in;
        for (int k = 0; k < 3; k++) begin
            nbhd[k*3]   = nbhd[k*3+1];
            nbhd[k*3+1] = nbhd[k*3+2];
        end
        nbhd[2] = above;
        nbhd[5] = mid;
        nbhd[8] = state_in;
        if (r >= 2 && c >= 2) begin
            live = 0;
            psum = '0;
            acc  = '0;
            if (set_moore) begin
                for (int i = 0; i < 9; i++) begin
                    if (i != 4 && nbhd[i] > 0) begin
                        live++;
                        psum += 32'(nbhd[i]);
                    end
                    term_s = nbhd[i];
                    term_w = $signed(set_weights[i/3][16*(i%3) +: 16]);
                    acc += term_s * term_w;
                end
                // signed division truncates toward zero
                acc = acc / (1 << FRAC_BITS);
            end
            res.row  = 16'(r - 1);
            res.col  = 10'(c - 1);
            res.live = 4'(live);
            res.psum = 18'(psum);
            res.wsum = acc[WSUM_W-1:0];
            pending_results.push_back(res);
        end
        raster_col = c + 1;
        if (raster_col >= cols) begin
            raster_col = 0;
            raster_row = r + 1;
            if (raster_row >= rows) raster_row = 0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        mwn_result_t want;
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: row %0d col %0d",
                                          m_center_row, m_center_col));
            end else begin
                want = pending_results.pop_front();
                if (m_center_row !== want.row)
                    report_mismatch($sformatf("centre row %0d, want %0d",
                                              m_center_row, want.row));
                if (m_center_col !== want.col)
                    report_mismatch($sformatf("centre col %0d, want %0d",
                                              m_center_col, want.col));
                if (m_live_count !== want.live)
                    report_mismatch($sformatf("live count %0d, want %0d at (%0d,%0d)",
                                              m_live_count, want.live, want.row, want.col));
                if (m_positive_sum !== want.psum)
                    report_mismatch($sformatf("positive sum %0d, want %0d at (%0d,%0d)",
                                              m_positive_sum, want.psum, want.row, want.col));
                if (m_weighted_total !== want.wsum)
                    report_mismatch($sformatf("weighted total %0d, want %0d at (%0d,%0d)",
                                              m_weighted_total, $signed(want.wsum),
                                              want.row, want.col));
            end
        end
    end

    // end the run if no transfer happens on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL moore_window_neighbor_engine");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cell(input logic signed [15:0] value, input logic start);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cell_value  <= value;
        s_frame_start <= start;
        do @(posedge aclk); while (!s_ready);
        slide_window(value, start);
    endtask

    // Hold the sender until every expected result has arrived and the pipe is empty.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PLANE_ROWS:  set_rows       = data[PLANE_ROWS_W-1:0];
            REG_PLANE_COLS:  set_cols       = data[PLANE_COLS_W-1:0];
            REG_MOORE_MODE:  set_moore      = data[0];
            REG_WEIGHTS_TOP: set_weights[0] = data;
            REG_WEIGHTS_MID: set_weights[1] = data;
            REG_WEIGHTS_BOT: set_weights[2] = data;
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_state();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom);
            4, 5, 6:    return 16'(int'($urandom_range(0, 8)) - 4);
            7: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sd1;
                    3: return -16'sd1;
                    default: return 16'sd0;
                endcase
            end
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return W_MOST_NEG;
            1: return W_MOST_POS;
            2: return W_ONE;
            3: return W_MINUS_LSB;
            4: return 16'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // default registers straight after reset: 3x3 plane, zero weights
    task automatic test_reset_values();
        logic signed [15:0] vals [9];
        vals = '{16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd0, 16'sh4000, -16'sd2,
                 16'sd2, 16'sh7FFF};
        for (int i = 0; i < 9; i++) send_cell(vals[i], i == 0);
    endtask

    // most negative weights with extreme states; second plane implied by wrap
    task automatic test_weight_extremes();
        drain();
        cfg_write(REG_WEIGHTS_TOP, {3{W_MOST_NEG}});
        cfg_write(REG_WEIGHTS_MID, {3{W_MOST_NEG}});
        cfg_write(REG_WEIGHTS_BOT, {3{W_MOST_NEG}});
        cfg_write(REG_SPARE_6, '1);
        cfg_write(REG_SPARE_7, '1);
        cfg_done();
        for (int i = 0; i < 9; i++) send_cell(16'sh8000, i == 0);
        for (int i = 0; i < 9; i++) send_cell(16'sh7FFF, 1'b0);
        drain();
        cfg_write(REG_WEIGHTS_MID, {W_MINUS_LSB, W_ONE, W_MOST_POS});
        cfg_done();
        for (int i = 0; i < 9; i++) send_cell(rand_state(), i == 0);
    endtask

    task automatic test_mode_off();
        drain();
        cfg_write(REG_MOORE_MODE, 48'd0);
        cfg_done();
        for (int i = 0; i < 9; i++) send_cell(rand_state(), i == 0);
        drain();
        cfg_write(REG_MOORE_MODE, 48'd1);
        cfg_done();
    endtask

    // geometry below the minimum acts as 3x3; junk above the field is dropped
    task automatic test_geometry_clamps();
        drain();
        cfg_write(REG_PLANE_ROWS, {32'hDEAD_BEEF, 16'd0});
        cfg_write(REG_PLANE_COLS, {37'h1F_FFFF_F800, 11'd1});
        cfg_done();
        for (int i = 0; i < 9; i++) send_cell(rand_state(), i == 0);
        drain();
        cfg_write(REG_PLANE_ROWS, 48'd2);
        cfg_write(REG_PLANE_COLS, 48'd0);
        cfg_done();
        for (int i = 0; i < 18; i++) send_cell(rand_state(), i == 0);
    endtask

    // Column count above the line depth acts as the full depth: run one full row
    // past the end, then narrow the plane so the next rows finish a window quickly.
    task automatic test_widest_plane();
        drain();
        cfg_write(REG_PLANE_ROWS, 48'd3);
        cfg_write(REG_PLANE_COLS, 48'd2047);
        cfg_write(REG_WEIGHTS_TOP, {rand_weight(), rand_weight(), rand_weight()});
        cfg_done();
        for (int i = 0; i < LINE_DEPTH + 2; i++) send_cell(rand_state(), i == 0);
        drain();
        cfg_write(REG_PLANE_COLS, 48'd3);
        cfg_done();
        for (int i = 0; i < 4; i++) send_cell(rand_state(), 1'b0);
    endtask

    // Shrink, grow and shrink the plane while part-way through it. Growing only
    // reaches columns that the widest plane has already filled.
    task automatic test_midplane_geometry();
        drain();
        cfg_write(REG_PLANE_ROWS, 48'd8);
        cfg_write(REG_PLANE_COLS, 48'd8);
        cfg_done();
        for (int i = 0; i < 20; i++) send_cell(rand_state(), i == 0);
        drain();
        cfg_write(REG_PLANE_COLS, 48'd3);
        cfg_done();
        for (int i = 0; i < 10; i++) send_cell(rand_state(), 1'b0);
        drain();
        cfg_write(REG_PLANE_COLS, 48'd10);
        cfg_done();
        for (int i = 0; i < 14; i++) send_cell(rand_state(), 1'b0);
        drain();
        cfg_write(REG_PLANE_ROWS, 48'd3);
        cfg_done();
        for (int i = 0; i < 12; i++) send_cell(rand_state(), 1'b0);
    endtask

    task automatic run_random_phase(input int n_items);
        int rows_val, cols_val, plane_len, pos;
        logic start;
        logic [CFG_DATA_W-1:0] data;
        drain();
        case ($urandom_range(0, 9))
            0:       rows_val = $urandom_range(0, 2);
            1:       rows_val = 65535;
            2:       rows_val = $urandom_range(9, 40);
            default: rows_val = $urandom_range(3, 8);
        endcase
        cols_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        data = $urandom_range(0, 1) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
        data[PLANE_ROWS_W-1:0] = rows_val[PLANE_ROWS_W-1:0];
        cfg_write(REG_PLANE_ROWS, data);
        data = $urandom_range(0, 1) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
        data[PLANE_COLS_W-1:0] = cols_val[PLANE_COLS_W-1:0];
        cfg_write(REG_PLANE_COLS, data);
        if ($urandom_range(0, 1))
            cfg_write(REG_MOORE_MODE, 48'($urandom_range(0, 99) < 85));
        if ($urandom_range(0, 99) < 60)
            cfg_write(REG_WEIGHTS_TOP, {rand_weight(), rand_weight(), rand_weight()});
        if ($urandom_range(0, 99) < 60)
            cfg_write(REG_WEIGHTS_MID, {rand_weight(), rand_weight(), rand_weight()});
        if ($urandom_range(0, 99) < 60)
            cfg_write(REG_WEIGHTS_BOT, {rand_weight(), rand_weight(), rand_weight()});
        cfg_done();
        plane_len = eff_rows() * eff_cols();
        pos = 0;
        for (int k = 0; k < n_items; k++) begin
            // mostly whole planes; now and then an implied start or a stray one
            start = (k == 0) || (pos == 0 && $urandom_range(0, 99) < 80)
                    || ($urandom_range(0, 99) < 2);
            if (start) pos = 0;
            send_cell(rand_state(), start);
            pos = (pos + 1) % plane_len;
        end
    endtask

    task automatic test_random_traffic();
        int idle_pct [4];
        int stall_pct [4];
        idle_pct  = '{0, 56, 0, 17};
        stall_pct = '{0, 0, 56, 17};
        for (int m = 0; m < 4; m++) begin
            src_idle_pct   = idle_pct[m];
            sink_stall_pct = stall_pct[m];
            run_random_phase(PHASE_ITEMS);
            run_random_phase(PHASE_ITEMS);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_weight_extremes();
        test_mode_off();
        test_geometry_clamps();
        test_widest_plane();
        test_midplane_geometry();
        test_random_traffic();
        drain();
        if (err_count == 0) begin
            $display("PASS moore_window_neighbor_engine");
        end else begin
            $display("FAIL moore_window_neighbor_engine");
        end
        $finish;
    end

endmodule
